// ===== hdl/crc_checked_frame_parser_assert.svh =====
// Assertion macros for the frame parser.
// CCFP_ASSERT checks a property outside reset, CCFP_ASSERT_RST checks it always.
`ifndef CRC_CHECKED_FRAME_PARSER_ASSERT_SVH
`define CRC_CHECKED_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

`define CCFP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define CCFP_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CCFP_ASSERT(label, clk, rstn, prop, msg)

`define CCFP_ASSERT_RST(label, clk, prop, msg)

`endif

`endif

// ===== hdl/ccfp_pkg.sv =====
`default_nettype none

package ccfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAX_LEN_W   = 11;
  localparam int INDEX_W     = 10;
  localparam int STATUS_W    = 2;
  localparam int CHECK_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam int MAX_LEN_REG       = (1 << MAX_LEN_W) - 1;
  localparam int PAYLOAD_LIMIT_DEF = 1024;

  localparam logic [CHECK_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CHECK_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CHECK_W-1:0] CRC_MSB  = 16'h8000;

  localparam logic [BYTE_W-1:0]    FIRST_SYNC_RST = 8'hAA;
  localparam logic [BYTE_W-1:0]    SECOND_SYNC_RST = 8'h55;
  localparam logic [BYTE_W-1:0]    END_MARKER_RST = 8'h55;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST    = 11'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_SYNC  = 2'd0,
    REG_SECOND_SYNC = 2'd1,
    REG_END_MARKER  = 2'd2,
    REG_MAX_LEN     = 2'd3
  } cfg_reg_e;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_GOOD    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_CRC = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_END = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0]    first_sync;
    logic [BYTE_W-1:0]    second_sync;
    logic [BYTE_W-1:0]    end_marker;
    logic [MAX_LEN_W-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } in_stage_t;

  function automatic logic [CHECK_W-1:0] crc16_byte(input logic [CHECK_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
    logic [CHECK_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ccfp_cfg.sv =====
`default_nettype none

module ccfp_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ccfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [ccfp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ccfp_pkg::cfg_t                           cfg
);

  ccfp_pkg::cfg_t cfg_r;
  ccfp_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (ccfp_pkg::cfg_reg_e'(cfg_index))
        ccfp_pkg::REG_FIRST_SYNC:  cfg_nxt.first_sync  = cfg_data[ccfp_pkg::BYTE_W-1:0];
        ccfp_pkg::REG_SECOND_SYNC: cfg_nxt.second_sync = cfg_data[ccfp_pkg::BYTE_W-1:0];
        ccfp_pkg::REG_END_MARKER:  cfg_nxt.end_marker  = cfg_data[ccfp_pkg::BYTE_W-1:0];
        ccfp_pkg::REG_MAX_LEN:     cfg_nxt.max_len     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_sync  <= ccfp_pkg::FIRST_SYNC_RST;
      cfg_r.second_sync <= ccfp_pkg::SECOND_SYNC_RST;
      cfg_r.end_marker  <= ccfp_pkg::END_MARKER_RST;
      cfg_r.max_len     <= ccfp_pkg::MAX_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ccfp_in_reg.sv =====
`default_nettype none

module ccfp_in_reg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ccfp_pkg::BYTE_W-1:0]    in_rx_byte,
  input  wire logic                           advance,
  output ccfp_pkg::in_stage_t                 in_q
);

  logic                        valid_r;
  logic [ccfp_pkg::BYTE_W-1:0] data_r;

  assign in_stall   = valid_r && !advance;
  assign in_q.valid = valid_r;
  assign in_q.data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ccfp_parse.sv =====
`default_nettype none

`include "crc_checked_frame_parser_assert.svh"

module ccfp_parse #(
  parameter int PAYLOAD_LIMIT = ccfp_pkg::PAYLOAD_LIMIT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ccfp_pkg::cfg_t                    cfg,
  input  wire ccfp_pkg::in_stage_t               in_q,
  output logic                                   advance,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_result_kind,
  output logic [ccfp_pkg::BYTE_W-1:0]            out_payload_byte,
  output logic [ccfp_pkg::INDEX_W-1:0]           out_payload_index,
  output logic [ccfp_pkg::BYTE_W-1:0]            out_frame_type,
  output logic [ccfp_pkg::BYTE_W-1:0]            out_frame_id,
  output logic [ccfp_pkg::MAX_LEN_W-1:0]         out_frame_length,
  output logic [ccfp_pkg::STATUS_W-1:0]          out_frame_status,
  output logic [ccfp_pkg::CHECK_W-1:0]           out_received_check,
  output logic [ccfp_pkg::CHECK_W-1:0]           out_computed_check
);

  localparam int LEN_MAX = (PAYLOAD_LIMIT < ccfp_pkg::MAX_LEN_REG) ?
                           PAYLOAD_LIMIT : ccfp_pkg::MAX_LEN_REG;
  localparam int CNT_W   = (LEN_MAX < 2) ? 1 : $clog2(LEN_MAX + 1);
  localparam int LW      = 2 * ccfp_pkg::BYTE_W;

  typedef enum logic [3:0] {
    PH_SYNC0 = 4'd0,
    PH_SYNC1 = 4'd1,
    PH_TYPE  = 4'd2,
    PH_ID    = 4'd3,
    PH_LENLO = 4'd4,
    PH_LENHI = 4'd5,
    PH_DATA  = 4'd6,
    PH_CRCLO = 4'd7,
    PH_CRCHI = 4'd8,
    PH_END   = 4'd9
  } phase_t;

  phase_t                             phase_r, phase_nxt;
  logic [ccfp_pkg::BYTE_W-1:0]        type_r, type_nxt;
  logic [ccfp_pkg::BYTE_W-1:0]        id_r, id_nxt;
  logic [ccfp_pkg::MAX_LEN_W-1:0]     len_r, len_nxt;
  logic [CNT_W-1:0]                   seen_r, seen_nxt;
  logic [ccfp_pkg::CHECK_W-1:0]       crc_r, crc_nxt;
  logic [ccfp_pkg::CHECK_W-1:0]       carried_r, carried_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               kind_r, kind_nxt;
  logic [ccfp_pkg::BYTE_W-1:0]        pbyte_r, pbyte_nxt;
  logic [ccfp_pkg::INDEX_W-1:0]       pidx_r, pidx_nxt;
  logic [ccfp_pkg::BYTE_W-1:0]        ftype_r, ftype_nxt;
  logic [ccfp_pkg::BYTE_W-1:0]        fid_r, fid_nxt;
  logic [ccfp_pkg::MAX_LEN_W-1:0]     flen_r, flen_nxt;
  logic [ccfp_pkg::STATUS_W-1:0]      fstat_r, fstat_nxt;
  logic [ccfp_pkg::CHECK_W-1:0]       rxchk_r, rxchk_nxt;
  logic [ccfp_pkg::CHECK_W-1:0]       calc_r, calc_nxt;

  logic                               fire;
  logic                               emit;
  logic [ccfp_pkg::BYTE_W-1:0]        b;
  logic [ccfp_pkg::CHECK_W-1:0]       crc_upd;
  logic [LW-1:0]                      full_len;
  logic [LW-1:0]                      limit;
  logic [LW:0]                        seen_inc;
  logic [LW-1:0]                      seen_wide;

  assign advance = !out_valid_r || !out_stall;
  assign fire    = in_q.valid && advance;
  assign b       = in_q.data;
  assign crc_upd = ccfp_pkg::crc16_byte(crc_r, b);

  assign full_len  = {b, len_r[ccfp_pkg::BYTE_W-1:0]};
  assign limit     = (LW'(cfg.max_len) > LW'(LEN_MAX)) ? LW'(LEN_MAX) : LW'(cfg.max_len);
  assign seen_wide = LW'(seen_r);
  assign seen_inc  = (LW + 1)'(seen_r) + (LW + 1)'(1);

  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    seen_nxt    = seen_r;
    crc_nxt     = crc_r;
    carried_nxt = carried_r;
    emit        = 1'b0;
    kind_nxt    = kind_r;
    pbyte_nxt   = pbyte_r;
    pidx_nxt    = pidx_r;
    ftype_nxt   = ftype_r;
    fid_nxt     = fid_r;
    flen_nxt    = flen_r;
    fstat_nxt   = fstat_r;
    rxchk_nxt   = rxchk_r;
    calc_nxt    = calc_r;

    if (fire) begin
      unique case (phase_r)
        PH_SYNC1: begin
          if (b == cfg.second_sync) begin
            phase_nxt   = PH_TYPE;
            type_nxt    = '0;
            id_nxt      = '0;
            len_nxt     = '0;
            seen_nxt    = '0;
            carried_nxt = '0;
            crc_nxt     = ccfp_pkg::CRC_INIT;
          end else if (b != cfg.first_sync) begin
            phase_nxt = PH_SYNC0;
          end
        end
        PH_TYPE: begin
          type_nxt  = b;
          crc_nxt   = crc_upd;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          id_nxt    = b;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          len_nxt   = ccfp_pkg::MAX_LEN_W'(b);
          crc_nxt   = crc_upd;
          phase_nxt = PH_LENHI;
        end
        PH_LENHI: begin
          len_nxt  = full_len[ccfp_pkg::MAX_LEN_W-1:0];
          crc_nxt  = crc_upd;
          seen_nxt = '0;
          if (full_len > limit) begin
            phase_nxt = PH_SYNC0;
          end else if (full_len == '0) begin
            phase_nxt = PH_CRCLO;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          crc_nxt  = crc_upd;
          seen_nxt = CNT_W'(seen_inc);
          if (seen_inc >= (LW + 1)'(len_r)) begin
            phase_nxt = PH_CRCLO;
          end
          emit      = 1'b1;
          kind_nxt  = ccfp_pkg::KIND_PAYLOAD;
          pbyte_nxt = b;
          pidx_nxt  = seen_wide[ccfp_pkg::INDEX_W-1:0];
          fstat_nxt = ccfp_pkg::STAT_GOOD;
          rxchk_nxt = '0;
          calc_nxt  = '0;
        end
        PH_CRCLO: begin
          carried_nxt = ccfp_pkg::CHECK_W'(b);
          phase_nxt   = PH_CRCHI;
        end
        PH_CRCHI: begin
          carried_nxt = {b, carried_r[ccfp_pkg::BYTE_W-1:0]};
          phase_nxt   = PH_END;
        end
        PH_END: begin
          phase_nxt = PH_SYNC0;
          emit      = 1'b1;
          kind_nxt  = ccfp_pkg::KIND_STATUS;
          pbyte_nxt = '0;
          pidx_nxt  = '0;
          if (b != cfg.end_marker) begin
            fstat_nxt = ccfp_pkg::STAT_BAD_END;
          end else if (crc_r == carried_r) begin
            fstat_nxt = ccfp_pkg::STAT_GOOD;
          end else begin
            fstat_nxt = ccfp_pkg::STAT_BAD_CRC;
          end
          rxchk_nxt = carried_r;
          calc_nxt  = crc_r;
        end
        default: begin
          phase_nxt = (b == cfg.first_sync) ? PH_SYNC1 : PH_SYNC0;
        end
      endcase
      if (emit) begin
        ftype_nxt = type_r;
        fid_nxt   = id_r;
        flen_nxt  = len_r;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC0;
      type_r      <= '0;
      id_r        <= '0;
      len_r       <= '0;
      seen_r      <= '0;
      crc_r       <= ccfp_pkg::CRC_INIT;
      carried_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      type_r      <= type_nxt;
      id_r        <= id_nxt;
      len_r       <= len_nxt;
      seen_r      <= seen_nxt;
      crc_r       <= crc_nxt;
      carried_r   <= carried_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    pbyte_r <= pbyte_nxt;
    pidx_r  <= pidx_nxt;
    ftype_r <= ftype_nxt;
    fid_r   <= fid_nxt;
    flen_r  <= flen_nxt;
    fstat_r <= fstat_nxt;
    rxchk_r <= rxchk_nxt;
    calc_r  <= calc_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_payload_byte   = pbyte_r;
  assign out_payload_index  = pidx_r;
  assign out_frame_type     = ftype_r;
  assign out_frame_id       = fid_r;
  assign out_frame_length   = flen_r;
  assign out_frame_status   = fstat_r;
  assign out_received_check = rxchk_r;
  assign out_computed_check = calc_r;

  `CCFP_ASSERT_RST(a_reset_clears, clk, !rst_n |=> (phase_r == PH_SYNC0) && !out_valid_r, "reset did not clear parser")
  `CCFP_ASSERT(a_data_in_range, clk, rst_n, (phase_r == PH_DATA) |-> (LW'(seen_r) < LW'(len_r)), "payload count past length")
  `CCFP_ASSERT(a_end_gives_status, clk, rst_n, (fire && (phase_r == PH_END)) |=> (out_valid_r && (kind_r == ccfp_pkg::KIND_STATUS)), "end byte gave no status")
  `CCFP_ASSERT(a_payload_clean, clk, rst_n, (out_valid_r && (kind_r == ccfp_pkg::KIND_PAYLOAD)) |-> ((fstat_r == ccfp_pkg::STAT_GOOD) && (rxchk_r == '0) && (calc_r == '0)), "payload result carries status")
  `CCFP_ASSERT(a_stall_blocks_input, clk, rst_n, (out_valid_r && out_stall) |-> !fire, "byte consumed while result stalled")

endmodule

`default_nettype wire

// ===== hdl/crc_checked_frame_parser.sv =====
// Byte-stream frame deframer: hunts for two programmable sync bytes, reads type, id and a
// little-endian 16-bit length, passes each payload byte out at once with its index, then
// checks a little-endian CRC-16/CCITT-FALSE (over type, id, length and payload) and the end
// marker and reports one status result. Lengths above the smaller of the max_len register
// and PAYLOAD_LIMIT drop the frame silently. One byte is taken every cycle while the result
// is not stalled; an accepted byte lands in the input register and its result then goes
// into the result register, the byte-wide CRC update and phase decode being combinational.
// A stalled result holds the input register, which then stalls the input channel.
`default_nettype none

module crc_checked_frame_parser #(
  parameter int PAYLOAD_LIMIT = ccfp_pkg::PAYLOAD_LIMIT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ccfp_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_result_kind,
  output logic [ccfp_pkg::BYTE_W-1:0]            out_payload_byte,
  output logic [ccfp_pkg::INDEX_W-1:0]           out_payload_index,
  output logic [ccfp_pkg::BYTE_W-1:0]            out_frame_type,
  output logic [ccfp_pkg::BYTE_W-1:0]            out_frame_id,
  output logic [ccfp_pkg::MAX_LEN_W-1:0]         out_frame_length,
  output logic [ccfp_pkg::STATUS_W-1:0]          out_frame_status,
  output logic [ccfp_pkg::CHECK_W-1:0]           out_received_check,
  output logic [ccfp_pkg::CHECK_W-1:0]           out_computed_check,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ccfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ccfp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ccfp_pkg::cfg_t      cfg;
  ccfp_pkg::in_stage_t in_q;
  logic                advance;

  ccfp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ccfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .in_q       (in_q)
  );

  ccfp_parse #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_parse (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_q               (in_q),
    .advance            (advance),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_frame_type     (out_frame_type),
    .out_frame_id       (out_frame_id),
    .out_frame_length   (out_frame_length),
    .out_frame_status   (out_frame_status),
    .out_received_check (out_received_check),
    .out_computed_check (out_computed_check)
  );

endmodule

`default_nettype wire
